// ===== rtl/sha256_message_hasher_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH

// Same-cycle implication.
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Types, constants and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned LEN_POS     = 56;
	localparam int unsigned ROUNDS      = 64;
	localparam logic [31:0] PAD_WORD    = 32'h0000_0080 << 24;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [3:0] {
		S_IDLE, S_INS, S_PAD, S_ZERO, S_LEN, S_LCMP, S_RND, S_CEND, S_OUT
	} state_t;

	typedef struct packed {
		logic       load_word;
		logic       insert;
		logic       load_pad;
		logic       zero_fill;
		logic       put_length;
		logic       comp_start;
		logic       round;
		logic       comp_end;
		logic       hash_reset;
		logic [5:0] round_idx;
		logic [2:0] out_idx;
	} cmd_t;

	typedef struct packed {
		logic [6:0] fill;
		logic [2:0] pend_cnt;
	} stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] v);
		return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] v);
		return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] v);
		return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] v);
		return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/sha256_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
interface sha256_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  valid_bytes;
	logic        last_word;

	modport source (output valid, data_word, valid_bytes, last_word, input ready);
	modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  digest_index;
	logic        digest_last;

	modport source (output valid, digest_word, digest_index, digest_last, input ready);
	modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

// ===== rtl/sha256_message_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Streams a message in 32-bit words and returns its eight-word SHA-256 digest.
// ----------------------------------------------------------------------------
//  Channel     Direction  Payload
//  msg_in      in         data_word[31:0], valid_bytes[2:0], last_word
//  digest_out  out        digest_word[31:0], digest_index[2:0], digest_last
//
// A word is accepted, its bytes are packed into the block buffer and the block
// returns to idle. A word whose bytes straddle a block end is packed in two
// parts around the compression of the full block. Every completed 64-byte
// block then passes the single round unit (load, 64 rounds, hash update). The
// final block adds pad, zero fill and length steps, plus one more block when
// fewer than 8 bytes are left. Reset returns the chained hash to the initial
// values and clears the byte and bit counts. A stalled digest transaction
// holds the block; no word is taken until the last digest word is accepted.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
	input logic                clk,
	input logic                arst_n,
	sha256_in_if.sink          msg_in,
	sha256_out_if.source       digest_out
);

	sha256_pkg::cmd_t  cmd;
	sha256_pkg::stat_t stat;
	logic              in_ready;
	logic              out_valid;

	// The controller owns every handshake; the datapath sees only commands and payload.
	sha256_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg_in.valid),
		.in_ready  (in_ready),
		.in_last   (msg_in.last_word),
		.out_valid (out_valid),
		.out_ready (digest_out.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// The datapath packs bytes, runs the rounds and holds the chained hash,
	// whose selected word drives the digest transaction directly.
	sha256_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.data_word   (msg_in.data_word),
		.valid_bytes (msg_in.valid_bytes),
		.digest_word (digest_out.digest_word)
	);

	assign msg_in.ready            = in_ready;
	assign digest_out.valid        = out_valid;
	assign digest_out.digest_index = cmd.out_idx;
	assign digest_out.digest_last  = cmd.out_idx == 3'd7;

endmodule

// ===== rtl/sha256_dp.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Byte packer, message schedule, round logic and chained hash.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_defines.svh"

module sha256_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sha256_pkg::cmd_t  cmd,
	output sha256_pkg::stat_t stat,
	input  logic [31:0]       data_word,
	input  logic [2:0]        valid_bytes,
	output logic [31:0]       digest_word
);

	logic [511:0] buf_q;
	logic [6:0]   fill_q;
	logic [31:0]  pend_q;
	logic [2:0]   pcnt_q;
	logic [63:0]  bits_q;
	logic [31:0]  hash_q [8];
	logic [31:0]  var_q [8];
	logic [31:0]  win_q [16];

	logic [6:0]   avail;
	logic [6:0]   zlim;
	logic [2:0]   nins;
	logic [2:0]   nzero;
	logic [2:0]   nsh;
	logic [31:0]  src;
	logic [511:0] buf_sh;
	logic [31:0]  pend_sh;
	logic [2:0]   vb_clamp;
	logic [31:0]  w_new;
	logic [31:0]  t1;
	logic [31:0]  t2;

	assign avail = 7'(sha256_pkg::BLOCK_BYTES) - fill_q;
	assign nins  = (avail < {4'd0, pcnt_q}) ? avail[2:0] : pcnt_q;
	assign zlim  = (fill_q < 7'(sha256_pkg::LEN_POS)) ?
		7'(sha256_pkg::LEN_POS) - fill_q : avail;
	assign nzero = (zlim < 7'd4) ? zlim[2:0] : 3'd4;
	assign nsh   = cmd.zero_fill ? nzero : nins;
	assign src   = cmd.zero_fill ? 32'h0 : pend_q;
	assign vb_clamp = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

	// Append up to four bytes at the low end of the block buffer.
	always_comb begin
		case (nsh)
			3'd1: begin
				buf_sh  = {buf_q[503:0], src[31:24]};
				pend_sh = {pend_q[23:0], 8'h0};
			end
			3'd2: begin
				buf_sh  = {buf_q[495:0], src[31:16]};
				pend_sh = {pend_q[15:0], 16'h0};
			end
			3'd3: begin
				buf_sh  = {buf_q[487:0], src[31:8]};
				pend_sh = {pend_q[7:0], 24'h0};
			end
			3'd4: begin
				buf_sh  = {buf_q[479:0], src};
				pend_sh = 32'h0;
			end
			default: begin
				buf_sh  = buf_q;
				pend_sh = pend_q;
			end
		endcase
	end

	assign w_new = win_q[0] + sha256_pkg::ssig0(win_q[1]) + win_q[9]
		+ sha256_pkg::ssig1(win_q[14]);
	assign t1 = var_q[7] + sha256_pkg::bsig1(var_q[4])
		+ ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
		+ sha256_pkg::round_k(cmd.round_idx) + win_q[0];
	assign t2 = sha256_pkg::bsig0(var_q[0])
		+ ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pcnt_q <= '0;
			bits_q <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::IV[i];
		end else begin
			if (cmd.load_word) begin
				pend_q <= data_word;
				pcnt_q <= vb_clamp;
				bits_q <= bits_q + {58'd0, vb_clamp, 3'd0};
			end
			if (cmd.load_pad) begin
				pend_q <= sha256_pkg::PAD_WORD;
				pcnt_q <= 3'd1;
			end
			if (cmd.insert || cmd.zero_fill) begin
				buf_q  <= buf_sh;
				fill_q <= fill_q + {4'd0, nsh};
				if (cmd.insert) begin
					pend_q <= pend_sh;
					pcnt_q <= pcnt_q - nsh;
				end
			end
			if (cmd.put_length) begin
				buf_q  <= {buf_q[447:0], bits_q};
				fill_q <= 7'(sha256_pkg::BLOCK_BYTES);
			end
			if (cmd.comp_start) begin
				fill_q <= '0;
				for (int i = 0; i < 16; i++) win_q[i] <= buf_q[511 - 32 * i -: 32];
				for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
			end
			if (cmd.round) begin
				for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
				win_q[15] <= w_new;
				var_q[7] <= var_q[6];
				var_q[6] <= var_q[5];
				var_q[5] <= var_q[4];
				var_q[4] <= var_q[3] + t1;
				var_q[3] <= var_q[2];
				var_q[2] <= var_q[1];
				var_q[1] <= var_q[0];
				var_q[0] <= t1 + t2;
			end
			if (cmd.comp_end) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
			end
			if (cmd.hash_reset) begin
				bits_q <= '0;
				for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::IV[i];
			end
		end
	end

	assign stat.fill     = fill_q;
	assign stat.pend_cnt = pcnt_q;
	assign digest_word   = hash_q[cmd.out_idx];

	`SHA_ASSERT_IMP(a_fill_range, 1'b1, fill_q <= 7'(sha256_pkg::BLOCK_BYTES), "fill above block")
	`SHA_ASSERT_IMP(a_no_overfill, cmd.insert || cmd.zero_fill,
		fill_q != 7'(sha256_pkg::BLOCK_BYTES), "byte appended to full block")
	`SHA_ASSERT_NXT(a_start_clears, cmd.comp_start, fill_q == 7'd0, "fill not cleared")

endmodule

// ===== rtl/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences word intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_defines.svh"

module sha256_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_last,
	output logic              out_valid,
	input  logic              out_ready,
	output sha256_pkg::cmd_t  cmd,
	input  sha256_pkg::stat_t stat
);

	sha256_pkg::state_t state_q, state_n, ret_q, ret_n;
	logic [5:0] round_q, round_n;
	logic [2:0] oidx_q, oidx_n;
	logic       last_q, last_n;
	logic       tail_q, tail_n;
	logic       full;

	assign full = stat.fill == 7'(sha256_pkg::BLOCK_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::S_IDLE;
			ret_q   <= sha256_pkg::S_IDLE;
			round_q <= '0;
			oidx_q  <= '0;
			last_q  <= 1'b0;
			tail_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			ret_q   <= ret_n;
			round_q <= round_n;
			oidx_q  <= oidx_n;
			last_q  <= last_n;
			tail_q  <= tail_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		ret_n     = ret_q;
		round_n   = round_q;
		oidx_n    = oidx_q;
		last_n    = last_q;
		tail_n    = tail_q;
		cmd       = '0;
		cmd.round_idx = round_q;
		cmd.out_idx   = oidx_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			sha256_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_word = 1'b1;
					last_n  = in_last;
					state_n = sha256_pkg::S_INS;
				end
			end
			sha256_pkg::S_INS: begin
				if (full) begin
					cmd.comp_start = 1'b1;
					ret_n   = sha256_pkg::S_INS;
					round_n = '0;
					state_n = sha256_pkg::S_RND;
				end else if (stat.pend_cnt == 3'd0) begin
					if (tail_q)
						state_n = sha256_pkg::S_ZERO;
					else if (last_q)
						state_n = sha256_pkg::S_PAD;
					else
						state_n = sha256_pkg::S_IDLE;
				end else begin
					cmd.insert = 1'b1;
				end
			end
			sha256_pkg::S_PAD: begin
				cmd.load_pad = 1'b1;
				last_n  = 1'b0;
				tail_n  = 1'b1;
				state_n = sha256_pkg::S_INS;
			end
			sha256_pkg::S_ZERO: begin
				if (full) begin
					cmd.comp_start = 1'b1;
					ret_n   = sha256_pkg::S_ZERO;
					round_n = '0;
					state_n = sha256_pkg::S_RND;
				end else if (stat.fill == 7'(sha256_pkg::LEN_POS)) begin
					state_n = sha256_pkg::S_LEN;
				end else begin
					cmd.zero_fill = 1'b1;
				end
			end
			sha256_pkg::S_LEN: begin
				cmd.put_length = 1'b1;
				state_n = sha256_pkg::S_LCMP;
			end
			sha256_pkg::S_LCMP: begin
				cmd.comp_start = 1'b1;
				ret_n   = sha256_pkg::S_OUT;
				round_n = '0;
				state_n = sha256_pkg::S_RND;
			end
			sha256_pkg::S_RND: begin
				cmd.round = 1'b1;
				round_n   = round_q + 6'd1;
				if (round_q == 6'(sha256_pkg::ROUNDS - 1))
					state_n = sha256_pkg::S_CEND;
			end
			sha256_pkg::S_CEND: begin
				cmd.comp_end = 1'b1;
				state_n = ret_q;
			end
			sha256_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (oidx_q == 3'd7) begin
						cmd.hash_reset = 1'b1;
						oidx_n  = '0;
						tail_n  = 1'b0;
						state_n = sha256_pkg::S_IDLE;
					end else begin
						oidx_n = oidx_q + 3'd1;
					end
				end
			end
			default: state_n = sha256_pkg::S_IDLE;
		endcase
	end

	`SHA_ASSERT_NXT(a_round_end, state_q == sha256_pkg::S_RND && round_q == 6'd63,
		state_q == sha256_pkg::S_CEND, "round counter did not end compression")
	`SHA_ASSERT_NXT(a_digest_done, out_valid && out_ready && oidx_q == 3'd7,
		state_q == sha256_pkg::S_IDLE && !tail_q, "digest end did not return to idle")
	`SHA_ASSERT_IMP(a_excl_hs, 1'b1, !(in_ready && out_valid), "both channels active")

endmodule
